[sv/mfd_pkg.sv]
// Shared types and constants for the message frame deframer.
`default_nettype none

package mfd_pkg;

    localparam int HEADER_BYTES = 12;
    localparam int HPOS_W       = $clog2(HEADER_BYTES);

    localparam logic [HPOS_W-1:0] HPOS_VERSION = HPOS_W'(4);
    localparam logic [HPOS_W-1:0] HPOS_TYPE    = HPOS_W'(6);
    localparam logic [HPOS_W-1:0] HPOS_LENGTH  = HPOS_W'(8);
    localparam logic [HPOS_W-1:0] HPOS_LAST    = HPOS_W'(HEADER_BYTES - 1);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_MAGIC   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_VERSION = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_MAXLEN  = CFG_INDEX_W'(2);

    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65536;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DISCARD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_TRUNC   = 3'd1,
        ERR_MAGIC   = 3'd2,
        ERR_VERSION = 3'd3,
        ERR_LARGE   = 3'd4,
        ERR_SIZE    = 3'd5
    } err_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        kind_t      result_kind;
        logic [7:0] payload_byte;
        logic [7:0] message_type;
        logic       last_of_message;
        err_t       error_code;
    } out_item_t;

endpackage

`default_nettype wire

[sv/message_frame_deframer.sv]
// Message frame deframer: header parse, checks and payload forwarding.
// Results are registered on the input transfer, into the output register or skid.
// Throughput: one byte per cycle while in_stall is low; the parse state updates on each accepted byte.
// A two-entry output buffer (output register plus skid) keeps input moving while a
// result waits; input stalls only when both entries are full.
// Reset (async, active low): header phase, position zero, output empty,
// max_payload 65536, expected magic and expected version zero.
`default_nettype none

module message_frame_deframer (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire mfd_pkg::in_item_t                  in_data,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output mfd_pkg::out_item_t                      out_data,
    input  wire logic                               cfg_write,
    input  wire logic [mfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [mfd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mfd_pkg::*;

    // configuration
    logic [31:0] exp_magic_reg;
    logic [15:0] exp_version_reg;
    logic [31:0] max_payload_reg;

    // parse state
    phase_t            phase_reg, phase_next;
    logic [HPOS_W-1:0] hpos_reg, hpos_next;
    logic [31:0]       magic_reg, magic_next;
    logic [15:0]       version_reg, version_next;
    logic [7:0]        type_reg, type_next;
    logic [23:0]       length_reg, length_next;
    logic [31:0]       remain_reg, remain_next;

    // output buffer
    logic      out_valid_reg, skid_valid_reg;
    out_item_t out_item_reg, skid_item_reg;

    logic        in_fire, out_fire, push;
    out_item_t   result;
    logic [31:0] length_full, remain_dec;
    logic [7:0]  b;
    logic        end_mark;

    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;

    assign b           = in_data.data_byte;
    assign end_mark    = in_data.frame_end;
    assign length_full = {b, length_reg};
    assign remain_dec  = remain_reg - 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_magic_reg   <= '0;
            exp_version_reg <= '0;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MAGIC:   exp_magic_reg   <= cfg_data;
                REG_VERSION: exp_version_reg <= cfg_data[15:0];
                REG_MAXLEN:  max_payload_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // one byte step
    always_comb
    begin
        phase_next   = phase_reg;
        hpos_next    = hpos_reg;
        magic_next   = magic_reg;
        version_next = version_reg;
        type_next    = type_reg;
        length_next  = length_reg;
        remain_next  = remain_reg;
        push         = 1'b0;
        result       = '{result_kind: KIND_BYTE, payload_byte: 8'd0, message_type: 8'd0,
                         last_of_message: 1'b0, error_code: ERR_NONE};

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (hpos_reg < HPOS_VERSION)
                    magic_next[{hpos_reg[1:0], 3'b000} +: 8] = b;
                else if (hpos_reg < HPOS_TYPE)
                    version_next[{hpos_reg[0], 3'b000} +: 8] = b;
                else if (hpos_reg == HPOS_TYPE)
                    type_next = b;
                else if (hpos_reg >= HPOS_LENGTH && hpos_reg < HPOS_LAST)
                    length_next[{hpos_reg[1:0], 3'b000} +: 8] = b;

                if (hpos_reg != HPOS_LAST)
                begin
                    if (end_mark)
                    begin
                        push              = 1'b1;
                        result.result_kind = KIND_ERROR;
                        result.error_code  = ERR_TRUNC;
                        hpos_next         = '0;
                    end
                    else
                        hpos_next = hpos_reg + HPOS_W'(1);
                end
                else
                begin
                    hpos_next = '0;
                    priority if (magic_reg != exp_magic_reg ||
                                 version_reg != exp_version_reg ||
                                 length_full > max_payload_reg ||
                                 (end_mark && length_full != 32'd0))
                    begin
                        push               = 1'b1;
                        result.result_kind = KIND_ERROR;
                        phase_next         = end_mark ? PH_HEADER : PH_DISCARD;
                        priority if (magic_reg != exp_magic_reg)
                            result.error_code = ERR_MAGIC;
                        else if (version_reg != exp_version_reg)
                            result.error_code = ERR_VERSION;
                        else if (length_full > max_payload_reg)
                            result.error_code = ERR_LARGE;
                        else
                            result.error_code = ERR_SIZE;
                    end
                    else if (end_mark)
                    begin
                        push                   = 1'b1;
                        result.result_kind     = KIND_EMPTY;
                        result.message_type    = type_reg;
                        result.last_of_message = 1'b1;
                    end
                    else
                    begin
                        remain_next = length_full;
                        phase_next  = PH_PAYLOAD;
                    end
                end
            end

            PH_PAYLOAD:
            begin
                push      = 1'b1;
                hpos_next = '0;
                if (remain_reg == 32'd0)
                begin
                    result.result_kind = KIND_ERROR;
                    result.error_code  = ERR_SIZE;
                    phase_next         = end_mark ? PH_HEADER : PH_DISCARD;
                end
                else
                begin
                    remain_next = remain_dec;
                    if (remain_dec == 32'd0)
                    begin
                        result.payload_byte    = b;
                        result.message_type    = type_reg;
                        result.last_of_message = 1'b1;
                        if (end_mark)
                            phase_next = PH_HEADER;
                    end
                    else if (end_mark)
                    begin
                        result.result_kind = KIND_ERROR;
                        result.error_code  = ERR_SIZE;
                        phase_next         = PH_HEADER;
                    end
                    else
                    begin
                        result.payload_byte = b;
                        result.message_type = type_reg;
                    end
                end
            end

            default:
            begin
                // discard, and the unused phase code
                if (end_mark)
                begin
                    phase_next = PH_HEADER;
                    hpos_next  = '0;
                end
                else
                    phase_next = PH_DISCARD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hpos_reg  <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            hpos_reg  <= hpos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            magic_reg   <= magic_next;
            version_reg <= version_next;
            type_reg    <= type_next;
            length_reg  <= length_next;
            remain_reg  <= remain_next;
        end
    end

    // output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (in_fire && push)
        begin
            if (!out_valid_reg || out_fire)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_fire)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_item_reg <= skid_item_reg;
        end
        else if (in_fire && push)
        begin
            if (!out_valid_reg || out_fire)
                out_item_reg <= result;
            else
                skid_item_reg <= result;
        end
    end

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_error_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.result_kind == KIND_ERROR |->
            out_item_reg.payload_byte == 8'd0 && out_item_reg.message_type == 8'd0 &&
            !out_item_reg.last_of_message && out_item_reg.error_code != ERR_NONE)
        else $error("error result carries payload fields");

    a_payload_hpos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_HEADER |-> hpos_reg == '0)
        else $error("header position nonzero outside header phase");

    a_hpos_range: assert property (@(posedge clk) disable iff (!rst_n)
        hpos_reg <= HPOS_LAST)
        else $error("header position beyond header");

    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !skid_valid_reg && !(in_fire && push) |=> !out_valid_reg)
        else $error("output stayed valid after last transfer");
`endif

endmodule

`default_nettype wire
